// ===== rtl/gbbp_pkg.sv =====
// constants and types shared by the gshare / bimodal branch predictor
// no dependencies
package gbbp_pkg;

	localparam int INDEX_BITS  = 10;
	localparam int TABLE_DEPTH = 1 << INDEX_BITS;
	localparam int PC_W        = 64;
	localparam int HLEN_W      = 4;
	localparam int CFG_W       = 4;
	localparam int IN_TDATA_W  = 2 * PC_W;
	localparam int OUT_TDATA_W = ((PC_W + 1 + 7) / 8) * 8;

	typedef logic [INDEX_BITS-1:0] idx_t;
	typedef logic [1:0]            ctr_t;

	localparam ctr_t CTR_RESET = 2'd1;
	localparam ctr_t CTR_TAKEN = 2'd2;
	localparam ctr_t CTR_MAX   = 2'd3;

	// configuration register indexes
	typedef enum logic {
		REG_MODE = 1'b0,
		REG_HLEN = 1'b1
	} reg_idx_t;

	localparam logic MODE_GSHARE = 1'b1;

endpackage

// ===== rtl/gshare_bimodal_branch_predictor.sv =====
// gshare / bimodal branch predictor with a branch target buffer
// counter table and target table held in synchronous memories
// depends on gbbp_pkg
//
// channel  dir  handshake         payload
// s        in   s_tvalid/tready   s_tdata: branch_pc [63:0], actual_next_pc [127:64]
// m        out  m_tvalid/tready   m_tdata: predicted_pc [63:0], mispredicted [64]
// cfg      in   cfg_we            cfg_index, cfg_data
//
// each branch is handled in order: the table read on acceptance, then the
// read-modify-write of the counter and target with the history update.
// after reset a clearing pass over all TABLE_DEPTH (1024) entries sets every counter
// to weakly not taken; no request is taken during it.
// a stalled output holds one finished result while the next branch is taken.
module gshare_bimodal_branch_predictor
	import gbbp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // branch_pc, actual_next_pc
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // predicted_pc, mispredicted, zero pad
	input  logic                   cfg_we,
	input  reg_idx_t               cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	ctr_t             ctr_mem [TABLE_DEPTH];
	logic [PC_W-1:0]  tgt_mem [TABLE_DEPTH];

	logic             mode_q;
	logic [HLEN_W-1:0] hlen_q;
	idx_t             hist_q;
	logic             clr_busy_q;
	idx_t             clr_addr_q;

	logic             valid_s1;
	idx_t             idx_s1;
	logic             taken_s1;
	logic [PC_W-1:0]  fall_s1;
	logic [PC_W-1:0]  actual_s1;
	ctr_t             ctr_rd_s1;
	logic [PC_W-1:0]  tgt_rd_s1;

	logic [PC_W-1:0]  pred_q;
	logic             mis_q;

	logic [PC_W-1:0]  in_pc;
	logic [PC_W-1:0]  in_actual;
	logic [PC_W-1:0]  in_fall;
	idx_t             hist_mask;
	idx_t             rd_idx;
	logic             accept;
	logic             done_s1;
	logic [PC_W-1:0]  pred_s1;
	ctr_t             ctr_new;
	logic             ctr_we;
	idx_t             ctr_wa;
	ctr_t             ctr_wd;

	assign in_pc     = s_tdata[PC_W-1:0];
	assign in_actual = s_tdata[2*PC_W-1:PC_W];
	assign in_fall   = in_pc + PC_W'(4);

	// bits below the configured length, clamped to the index width by construction
	always_comb begin
		for (int i = 0; i < INDEX_BITS; i++) begin
			hist_mask[i] = (i < int'(hlen_q));
		end
	end

	always_comb begin
		rd_idx = in_pc[3 +: INDEX_BITS];
		if (mode_q == MODE_GSHARE) begin
			rd_idx = rd_idx ^ (hist_q & hist_mask);
		end
	end

	assign s_tready = !clr_busy_q && !valid_s1;
	assign accept   = s_tvalid && s_tready;
	assign done_s1  = valid_s1 && (!m_tvalid || m_tready);

	assign pred_s1 = (ctr_rd_s1 >= CTR_TAKEN) ? tgt_rd_s1 : fall_s1;

	always_comb begin
		ctr_new = ctr_rd_s1;
		if (taken_s1) begin
			if (ctr_rd_s1 != CTR_MAX) begin
				ctr_new = ctr_rd_s1 + 2'd1;
			end
		end else if (ctr_rd_s1 != 2'd0) begin
			ctr_new = ctr_rd_s1 - 2'd1;
		end
	end

	// one write port, shared by the clearing pass and the update
	always_comb begin
		ctr_we = clr_busy_q || done_s1;
		ctr_wa = clr_busy_q ? clr_addr_q : idx_s1;
		ctr_wd = clr_busy_q ? CTR_RESET : ctr_new;
	end

	always_ff @(posedge clk) begin
		if (ctr_we) begin
			ctr_mem[ctr_wa] <= ctr_wd;
		end
		if (accept) begin
			ctr_rd_s1 <= ctr_mem[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (done_s1 && taken_s1) begin
			tgt_mem[idx_s1] <= actual_s1;
		end
		if (accept) begin
			tgt_rd_s1 <= tgt_mem[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1    <= rd_idx;
			taken_s1  <= (in_actual != in_fall);
			fall_s1   <= in_fall;
			actual_s1 <= in_actual;
		end
		if (done_s1) begin
			pred_q <= pred_s1;
			mis_q  <= (pred_s1 != actual_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			hlen_q     <= '0;
			hist_q     <= '0;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			valid_s1   <= 1'b0;
			m_tvalid   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE: mode_q <= cfg_data[0];
					REG_HLEN: hlen_q <= cfg_data[HLEN_W-1:0];
					default:  mode_q <= mode_q;
				endcase
			end
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + idx_t'(1);
				if (clr_addr_q == idx_t'(TABLE_DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (done_s1) begin
				valid_s1 <= 1'b0;
			end
			if (done_s1) begin
				m_tvalid <= 1'b1;
				if (mode_q == MODE_GSHARE) begin
					hist_q <= {hist_q[INDEX_BITS-2:0], taken_s1} & hist_mask;
				end
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	assign m_tdata = {{(OUT_TDATA_W-PC_W-1){1'b0}}, mis_q, pred_q};

`ifndef ASSERT_OFF
	a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !s_tready)
		else $error("request taken during clearing pass");

	a_accept_loads_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted branch lost before table read");

	a_done_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		done_s1 |=> m_tvalid && !valid_s1)
		else $error("finished branch did not reach the output");

	a_bimodal_keeps_history: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_GSHARE) |=> $stable(hist_q))
		else $error("history moved in bimodal mode");
`endif

endmodule

// ===== tb/gshare_bimodal_branch_predictor_checker.sv =====
// checker for the gshare / bimodal branch predictor: watches the request, result
// and config channels, predicts each result and compares it field by field
// depends on gbbp_pkg
module gshare_bimodal_branch_predictor_checker
	import gbbp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // branch_pc, actual_next_pc
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,   // predicted_pc, mispredicted, zero pad
	input  logic                   cfg_we,
	input  reg_idx_t               cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	output int                     failures,
	output int                     pending,
	output int                     checked,
	output int                     mispredictions
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [PC_W-1:0] pc_t;

	typedef struct packed {
		pc_t  predicted_pc;
		logic mispredicted;
	} prediction_t;

	localparam ctr_t CTR_MIN = '0;

	ctr_t              dir_ctr [TABLE_DEPTH];
	pc_t               btb     [TABLE_DEPTH];
	idx_t              ghist;
	logic              gshare_on;
	logic [HLEN_W-1:0] hist_len;
	prediction_t       expected_predictions [$];

	// history length is clamped to the index width
	function automatic idx_t hist_mask();
		int n;
		n = (hist_len > INDEX_BITS) ? INDEX_BITS : int'(hist_len);
		return idx_t'((1 << n) - 1);
	endfunction

	// look up, then train counter, target and history with the outcome
	function automatic prediction_t resolve_branch(pc_t pc, pc_t actual);
		pc_t         fall;
		logic        taken;
		idx_t        idx;
		prediction_t p;
		fall  = pc + pc_t'(4);
		taken = (actual != fall);
		idx   = pc[3 +: INDEX_BITS];
		if (gshare_on)
			idx = idx ^ (ghist & hist_mask());
		p.predicted_pc = (dir_ctr[idx] >= CTR_TAKEN) ? btb[idx] : fall;
		p.mispredicted = (p.predicted_pc != actual);
		if (taken) begin
			if (dir_ctr[idx] != CTR_MAX)
				dir_ctr[idx] = dir_ctr[idx] + 1'b1;
			btb[idx] = actual;
		end else if (dir_ctr[idx] != CTR_MIN) begin
			dir_ctr[idx] = dir_ctr[idx] - 1'b1;
		end
		if (gshare_on)
			ghist = {ghist[INDEX_BITS-2:0], taken} & hist_mask();
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		prediction_t got;
		prediction_t want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				dir_ctr[i] = CTR_RESET;
				btb[i]     = '0;
			end
			ghist     = '0;
			gshare_on = 1'b0;
			hist_len  = '0;
			expected_predictions.delete();
			failures       = 0;
			checked        = 0;
			mispredictions = 0;
		end else begin
			// results first: a request cannot complete at its own acceptance edge
			if (m_tvalid && m_tready) begin
				got = {m_tdata[PC_W-1:0], m_tdata[PC_W]};
				if (expected_predictions.size() == 0) begin
					$error("result with no request pending: predicted_pc %h", got.predicted_pc);
					failures++;
				end else begin
					want = expected_predictions.pop_front();
					checked++;
					if (got.mispredicted === 1'b1)
						mispredictions++;
					if (got.predicted_pc !== want.predicted_pc) begin
						$error("predicted_pc: expected %h, got %h",
							want.predicted_pc, got.predicted_pc);
						failures++;
					end
					if (got.mispredicted !== want.mispredicted) begin
						$error("mispredicted: expected %b, got %b",
							want.mispredicted, got.mispredicted);
						failures++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE: gshare_on = (cfg_data[0] == MODE_GSHARE);
					REG_HLEN: hist_len  = cfg_data[HLEN_W-1:0];
					default:  ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_predictions.push_back(
					resolve_branch(s_tdata[PC_W-1:0], s_tdata[2*PC_W-1:PC_W]));
		end
		pending = expected_predictions.size();
	end

endmodule

// ===== tb/gshare_bimodal_branch_predictor_tb.sv =====
// testbench top for the gshare / bimodal branch predictor: drives directed and
// random resolved branches under several predictor settings and idling mixes
// depends on gbbp_pkg, gshare_bimodal_branch_predictor and its checker
module gshare_bimodal_branch_predictor_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gbbp_pkg::*;

	typedef logic [PC_W-1:0] pc_t;

	localparam int CYCLE_LIMIT = 250_000;
	localparam int SITES       = 48;
	localparam int PHASE_ITEMS = 200;
	localparam pc_t PC_MAX     = '1;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we    = 1'b0;
	reg_idx_t               cfg_index = REG_MODE;
	logic [CFG_W-1:0]       cfg_data  = '0;

	int failures;
	int pending;
	int checked;
	int mispredictions;

	int cycles    = 0;
	int idle_pct  = 0;
	int stall_pct = 0;
	int settings  = 0;

	// branch sites with a fixed address, a current target and a behavior
	pc_t site_pc     [SITES];
	pc_t site_target [SITES];
	int  site_bias   [SITES];
	int  site_loop   [SITES];
	int  site_trip   [SITES];

	gshare_bimodal_branch_predictor i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	gshare_bimodal_branch_predictor_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.failures       (failures),
		.pending        (pending),
		.checked        (checked),
		.mispredictions (mispredictions)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("gshare_bimodal_branch_predictor_tb NOT OK");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic pc_t rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic pc_t pick_target(pc_t pc);
		pc_t t;
		t = ($urandom_range(1) == 0) ? rand64() : pc + pc_t'($urandom_range(4096)) * 4;
		if (t == pc + pc_t'(4))
			t = t + pc_t'(8);
		return t;
	endfunction

	// entered and left at a falling edge; valid stays up across back-to-back requests
	task automatic send_branch(pc_t pc, pc_t actual);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {actual, pc};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic configure(logic gshare, logic [HLEN_W-1:0] hlen);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_MODE;
		cfg_data  <= gshare ? CFG_W'(MODE_GSHARE) : '0;
		@(negedge clk);
		cfg_index <= REG_HLEN;
		cfg_data  <= CFG_W'(hlen);
		@(negedge clk);
		cfg_we <= 1'b0;
		settings++;
	endtask

	task automatic random_branch();
		int  s;
		pc_t pc;
		pc_t actual;
		logic taken;
		if ($urandom_range(99) < 80) begin
			s = $urandom_range(SITES - 1);
			if (site_loop[s] != 0) begin
				taken = (site_trip[s] != site_loop[s] - 1);
				site_trip[s] = (site_trip[s] + 1) % site_loop[s];
			end else begin
				taken = ($urandom_range(99) < site_bias[s]);
			end
			if ($urandom_range(99) < 3)
				site_target[s] = pick_target(site_pc[s]);
			pc     = site_pc[s];
			actual = taken ? site_target[s] : pc + pc_t'(4);
		end else begin
			pc = rand64();
			case ($urandom_range(2))
				0: actual = rand64();
				1: actual = pc + pc_t'(4);
				default: actual = pc;
			endcase
		end
		send_branch(pc, actual);
	endtask

	task automatic run_phase(logic gshare, logic [HLEN_W-1:0] hlen, int idle, int stall);
		configure(gshare, hlen);
		idle_pct  = idle;
		stall_pct = stall;
		repeat (PHASE_ITEMS) random_branch();
	endtask

	initial begin
		int bias_choice [5] = '{0, 10, 50, 90, 100};
		for (int i = 0; i < SITES; i++) begin
			// every fourth site aliases its neighbor's table entry from another address
			if (i % 4 == 1)
				site_pc[i] = site_pc[i-1] ^ ((rand64() | pc_t'(1)) << 13);
			else
				site_pc[i] = rand64();
			site_target[i] = pick_target(site_pc[i]);
			site_bias[i]   = bias_choice[$urandom_range(4)];
			site_loop[i]   = ($urandom_range(1) == 0) ? 0 : $urandom_range(8, 2);
			site_trip[i]   = 0;
		end

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// directed: bimodal, saturation at both ends, address wrap, aliasing
		configure(1'b0, '0);
		send_branch('0, 64'd4);
		send_branch('0, 64'd4);
		send_branch('0, PC_MAX);
		send_branch(PC_MAX, 64'd3);
		send_branch(PC_MAX, PC_MAX);
		send_branch(PC_MAX, '0);
		send_branch(PC_MAX, PC_MAX);
		send_branch(PC_MAX, PC_MAX);
		send_branch(PC_MAX, PC_MAX);
		send_branch(PC_MAX, 64'd3);
		send_branch(64'h8000_0000_0000_1FF8, 64'h8000_0000_0000_1FFC);
		send_branch(64'hFFFF_FFFF_FFFF_FFFC, '0);
		send_branch(64'h0000_0000_0000_1000, 64'h0000_0000_0000_0000);

		// directed: gshare with an overlong history, clamped to the index width
		configure(1'b1, 4'd15);
		for (int k = 0; k < 10; k++)
			send_branch(64'h0000_0000_0000_2000,
				(k % 3 == 2) ? 64'h0000_0000_0000_2004 : 64'h0000_0000_0000_0040);

		// random phases; history carries over while its length changes
		run_phase(1'b1, 4'd15, 0, 0);
		run_phase(1'b1, 4'd10, 51, 0);
		run_phase(1'b1, 4'd1, 0, 51);
		run_phase(1'b0, 4'd7, 15, 15);
		run_phase(1'b1, 4'($urandom_range(15)), 15, 15);
		run_phase(1'b1, 4'd4, 51, 0);
		run_phase(1'b1, 4'd0, 0, 0);

		drain();
		repeat (8) @(negedge clk);
		$display("%0d branches checked under %0d predictor settings, %0d of them mispredicted",
			checked, settings, mispredictions);
		if (failures == 0 && pending == 0) begin
			$display("gshare_bimodal_branch_predictor_tb OK");
		end else begin
			$display("gshare_bimodal_branch_predictor_tb NOT OK");
		end
		$finish;
	end

endmodule
